/* rtl/ithre_pkg.sv */
// shared constants and types of the ipv4 tcp/rtp header extractor
`default_nettype none

package ithre_pkg;

    // byte counter width and its saturation value
    localparam int unsigned COUNT_BITS = 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // width for the length comparisons, one bit above the counter
    localparam int unsigned CMP_W = COUNT_BITS + 1;

    // stream widths
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned RES_W       = 68;
    localparam int unsigned OUT_TDATA_W = 72;

    // protocol values and header thresholds
    localparam logic [3:0] IP_VERSION_4   = 4'd4;
    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [7:0] PROTO_UDP      = 8'd17;
    localparam int unsigned MIN_HDR_BYTES = 20;
    localparam int unsigned MIN_RTP_LEN   = 40;
    localparam int unsigned UDP_HDR_BYTES = 8;
    localparam logic [15:0] MIN_UDP_LEN   = 16'd20;

    // byte positions in the ip header
    localparam int unsigned IDX_VER_IHL  = 0;
    localparam int unsigned IDX_PROTOCOL = 9;

    // byte positions relative to the end of the ip header
    localparam int unsigned REL_SEQ_FIRST = 4;
    localparam int unsigned REL_SEQ_LAST  = 7;
    localparam int unsigned REL_ULEN_LAST = 5;
    localparam int unsigned REL_MARKER    = 9;
    localparam int unsigned REL_TS_FIRST  = 12;
    localparam int unsigned REL_TS_LAST   = 15;

    // one packet verdict
    typedef struct packed {
        logic        ipv4_ok;
        logic        tcp_valid;
        logic [31:0] tcp_sequence;
        logic        rtp_valid;
        logic [31:0] rtp_timestamp;
        logic        rtp_marker;
    } t_result;

endpackage

`default_nettype wire

/* rtl/ipv4_tcp_rtp_header_extractor_unit.sv */
// top level of the ipv4 tcp/rtp header extractor
//
// A packet enters one byte per transaction on the slave stream, starting at
// the ipv4 header; tdata[7:0] is the byte and tlast marks the final byte.
// Bytes that are not last produce nothing on the master stream. The last byte
// of each packet produces one verdict transaction with the ipv4, tcp and rtp
// check flags, the tcp sequence number, rtp timestamp and rtp marker.
// A byte sits in the input register while the header state and checks are
// evaluated, and for the last byte the verdict is then loaded from there into
// the output register, which drives o_m_tvalid. Throughput is one byte per
// cycle unless a last byte must wait for the output register, as below.
// When the master side stalls, a verdict waits in the output register while
// non-last bytes keep flowing; only a further last byte waits in the input
// register, and the slave tready drops until the verdict is taken.
// A synchronous active-low reset empties both registers and returns the
// byte count and all captured fields to zero.
`default_nettype none

module ipv4_tcp_rtp_header_extractor_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave stream: tdata = data_byte[7:0], tlast = last_byte
    input  wire logic                               i_s_tvalid,
    output      logic                               o_s_tready,
    input  wire logic [ithre_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  wire logic                               i_s_tlast,
    // master stream: tdata = ipv4_ok[0], tcp_valid[1], tcp_sequence[33:2],
    // rtp_valid[34], rtp_timestamp[66:35], rtp_marker[67], zeros[71:68]
    output      logic                               o_m_tvalid,
    input  wire logic                               i_m_tready,
    output      logic [ithre_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       r_m_valid;
    logic [ithre_pkg::OUT_TDATA_W-1:0] r_m_data;
    logic       w_out_free;
    logic       w_s1_go;
    ithre_pkg::t_result w_result;

    // stage advance control
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_s1_go    = r_s1_valid && (!r_s1_last || w_out_free);
    assign o_s_tready = !r_s1_valid || w_s1_go;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // header capture and checks
    ithre_hdr_state u_hdr_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_s1_go),
        .i_data_byte (r_s1_byte),
        .i_last_byte (r_s1_last),
        .o_result    (w_result)
    );

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_byte <= i_s_tdata[7:0];
            r_s1_last <= i_s_tlast;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_s1_go && r_s1_last) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_s1_go && r_s1_last) begin
            r_m_data <= {(ithre_pkg::OUT_TDATA_W - ithre_pkg::RES_W)'(0),
                         w_result.rtp_marker, w_result.rtp_timestamp,
                         w_result.rtp_valid, w_result.tcp_sequence,
                         w_result.tcp_valid, w_result.ipv4_ok};
        end
    end

    // checks on the verdict path
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_m_valid && !r_s1_valid)
        else $error("registers not emptied by reset");
    a_tcp_rtp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !(r_m_data[1] && r_m_data[34]))
        else $error("tcp and rtp both valid");
    a_tcp_needs_ip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_data[1] |-> r_m_data[0])
        else $error("tcp valid without ipv4 ok");
    a_marker_needs_rtp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_data[67] |-> r_m_data[34])
        else $error("rtp marker without rtp valid");

endmodule

`default_nettype wire

/* rtl/ithre_hdr_state.sv */
// per-packet header field capture and end-of-packet checks
`default_nettype none

module ithre_hdr_state (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_step,
    input  wire logic [7:0]               i_data_byte,
    input  wire logic                     i_last_byte,
    output ithre_pkg::t_result            o_result
);

    logic [ithre_pkg::COUNT_BITS-1:0] r_count, n_count;
    logic [3:0]  r_version, n_version;
    logic [3:0]  r_ihl, n_ihl;
    logic [7:0]  r_proto, n_proto;
    logic [3:0]  r_offset, n_offset;
    logic [15:0] r_udp_len, n_udp_len;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_ts, n_ts;
    logic        r_marker, n_marker;

    // capture the fields carried by the current byte
    always_comb begin
        logic [ithre_pkg::COUNT_BITS-1:0] hl;
        logic [ithre_pkg::COUNT_BITS-1:0] rel;
        n_count   = r_count;
        n_version = r_version;
        n_ihl     = r_ihl;
        n_proto   = r_proto;
        n_offset  = r_offset;
        n_udp_len = r_udp_len;
        n_seq     = r_seq;
        n_ts      = r_ts;
        n_marker  = r_marker;
        hl  = ithre_pkg::COUNT_BITS'({r_ihl, 2'b00});
        rel = r_count - hl;
        if (r_count != ithre_pkg::COUNT_MAX) begin
            n_count = r_count + 1'b1;
            if (r_count == ithre_pkg::COUNT_BITS'(ithre_pkg::IDX_VER_IHL)) begin
                n_version = i_data_byte[7:4];
                n_ihl     = i_data_byte[3:0];
            end else begin
                if (r_count == ithre_pkg::COUNT_BITS'(ithre_pkg::IDX_PROTOCOL)) begin
                    n_proto = i_data_byte;
                end
                if (r_count >= hl) begin
                    if (rel >= ithre_pkg::COUNT_BITS'(ithre_pkg::REL_SEQ_FIRST) &&
                        rel <= ithre_pkg::COUNT_BITS'(ithre_pkg::REL_SEQ_LAST)) begin
                        n_seq = {r_seq[23:0], i_data_byte};
                    end
                    if (rel >= ithre_pkg::COUNT_BITS'(ithre_pkg::REL_SEQ_FIRST) &&
                        rel <= ithre_pkg::COUNT_BITS'(ithre_pkg::REL_ULEN_LAST)) begin
                        n_udp_len = {r_udp_len[7:0], i_data_byte};
                    end
                    if (rel == ithre_pkg::COUNT_BITS'(ithre_pkg::REL_MARKER)) begin
                        n_marker = i_data_byte[7];
                    end
                    if (rel == ithre_pkg::COUNT_BITS'(ithre_pkg::REL_TS_FIRST)) begin
                        n_offset = i_data_byte[7:4];
                    end
                    if (rel >= ithre_pkg::COUNT_BITS'(ithre_pkg::REL_TS_FIRST) &&
                        rel <= ithre_pkg::COUNT_BITS'(ithre_pkg::REL_TS_LAST)) begin
                        n_ts = {r_ts[23:0], i_data_byte};
                    end
                end
            end
        end
    end

    // packet checks on the state including the current byte
    always_comb begin
        logic [ithre_pkg::CMP_W-1:0] len;
        logic [ithre_pkg::CMP_W-1:0] hl;
        logic [ithre_pkg::CMP_W-1:0] tcp_hl;
        logic ip_ok, hl_ok, tcp_ok, rtp_ok;
        len    = ithre_pkg::CMP_W'(n_count);
        hl     = ithre_pkg::CMP_W'({n_ihl, 2'b00});
        tcp_hl = ithre_pkg::CMP_W'({n_offset, 2'b00});
        ip_ok  = len >= ithre_pkg::CMP_W'(ithre_pkg::MIN_HDR_BYTES) &&
                 n_version == ithre_pkg::IP_VERSION_4;
        hl_ok  = hl >= ithre_pkg::CMP_W'(ithre_pkg::MIN_HDR_BYTES) && hl <= len;
        tcp_ok = ip_ok && hl_ok && n_proto == ithre_pkg::PROTO_TCP &&
                 hl + ithre_pkg::CMP_W'(ithre_pkg::MIN_HDR_BYTES) <= len &&
                 hl + tcp_hl <= len;
        rtp_ok = len >= ithre_pkg::CMP_W'(ithre_pkg::MIN_RTP_LEN) &&
                 n_version == ithre_pkg::IP_VERSION_4 && hl_ok &&
                 n_proto == ithre_pkg::PROTO_UDP &&
                 hl + ithre_pkg::CMP_W'(ithre_pkg::UDP_HDR_BYTES) <= len &&
                 n_udp_len >= ithre_pkg::MIN_UDP_LEN &&
                 hl + ithre_pkg::CMP_W'(ithre_pkg::MIN_HDR_BYTES) <= len;
        o_result.ipv4_ok       = ip_ok;
        o_result.tcp_valid     = tcp_ok;
        o_result.tcp_sequence  = tcp_ok ? n_seq : 32'd0;
        o_result.rtp_valid     = rtp_ok;
        o_result.rtp_timestamp = rtp_ok ? n_ts : 32'd0;
        o_result.rtp_marker    = rtp_ok & n_marker;
    end

    // state update, cleared after the last byte of a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_count   <= '0;
            r_version <= '0;
            r_ihl     <= '0;
            r_proto   <= '0;
            r_offset  <= '0;
            r_udp_len <= '0;
            r_seq     <= '0;
            r_ts      <= '0;
            r_marker  <= 1'b0;
        end else if (i_step) begin
            r_count   <= n_count;
            r_version <= n_version;
            r_ihl     <= n_ihl;
            r_proto   <= n_proto;
            r_offset  <= n_offset;
            r_udp_len <= n_udp_len;
            r_seq     <= n_seq;
            r_ts      <= n_ts;
            r_marker  <= n_marker;
        end
    end

    // checks on the field capture
    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last_byte) |=> (r_count == '0))
        else $error("byte count not cleared after last byte");
    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_last_byte && r_count != ithre_pkg::COUNT_MAX) |=>
        (r_count == $past(r_count) + 1'b1))
        else $error("byte count did not advance");
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_count) && $stable(r_seq) && $stable(r_ts))
        else $error("header state moved without a byte");

endmodule

`default_nettype wire
